// ----- sv/dtf_pkg.sv -----
package dtf_pkg;

    // Default sizes of the number path
    localparam int MANTISSA_BITS_DEF = 40;
    localparam int FRACTION_BITS_DEF = 16;

    // Fraction digits kept after the dot; later digits are dropped
    localparam int MAX_FRACTION_DIGITS = 12;

    // Fixed field widths
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 57;
    localparam int VALUE_MAG_W = VALUE_W - 1;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int FD_W        = 4;
    localparam int POW_W       = 40;
    localparam int WIDE_W      = 64;

    // Largest magnitude of the result, 2^56 - 1
    localparam logic [WIDE_W-1:0] VALUE_MAX = (64'd1 << VALUE_MAG_W) - 64'd1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_BLANKS = 3'b001,
        PH_BODY   = 3'b010,
        PH_ERROR  = 3'b100
    } phase_t;

    // Top-level sequencer
    typedef enum logic [2:0] {
        S_PARSE = 3'b001,
        S_DIV   = 3'b010,
        S_FIN   = 3'b100
    } seq_t;

    // Parser status handed to the sequencer
    typedef struct packed {
        logic            negative;
        logic            phase_error;
        logic            any_character;
        logic            overflowed;
        logic [FD_W-1:0] fraction_digits;
    } parse_flags_t;

    // Divisor for a count of fraction digits
    function automatic logic [POW_W-1:0] pow10(input logic [FD_W-1:0] k);
        logic [POW_W-1:0] p;
        case (k)
            4'd0:    p = 40'd1;
            4'd1:    p = 40'd10;
            4'd2:    p = 40'd100;
            4'd3:    p = 40'd1000;
            4'd4:    p = 40'd10000;
            4'd5:    p = 40'd100000;
            4'd6:    p = 40'd1000000;
            4'd7:    p = 40'd10000000;
            4'd8:    p = 40'd100000000;
            4'd9:    p = 40'd1000000000;
            4'd10:   p = 40'd10000000000;
            4'd11:   p = 40'd100000000000;
            default: p = 40'd1000000000000;
        endcase
        return p;
    endfunction

endpackage

// ----- sv/dtf_parse.sv -----
module dtf_parse #(
    parameter int MANTISSA_BITS = dtf_pkg::MANTISSA_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        char_valid,
    input  logic                        clear,
    input  logic [dtf_pkg::CHAR_W-1:0]  char_in,
    output logic [MANTISSA_BITS-1:0]    mantissa,
    output dtf_pkg::parse_flags_t       flags
);

    localparam int MW = MANTISSA_BITS;
    localparam int EW = MANTISSA_BITS + 4;

    dtf_pkg::phase_t                phase_reg, phase_next;
    logic                           neg_reg, neg_next;
    logic [MW-1:0]                  mant_reg, mant_next;
    logic [dtf_pkg::FD_W-1:0]       fd_reg, fd_next;
    logic                           dot_reg, dot_next;
    logic                           any_reg, any_next;
    logic                           ovf_reg, ovf_next;

    logic                           is_digit, is_blank, is_sign;
    logic [3:0]                     digit;
    logic [EW-1:0]                  ext, prod;
    logic                           take;

    // Character class and the multiply-by-ten step
    always_comb
    begin
        is_digit = char_in inside {[dtf_pkg::CH_ZERO:dtf_pkg::CH_NINE]};
        is_blank = char_in inside {dtf_pkg::CH_SPACE, [dtf_pkg::CH_TAB:dtf_pkg::CH_CR]};
        is_sign  = (char_in == dtf_pkg::CH_MINUS) || (char_in == dtf_pkg::CH_PLUS);
        digit    = 4'(char_in - dtf_pkg::CH_ZERO);
        ext      = {4'b0, mant_reg};
        prod     = (ext << 3) + (ext << 1) + EW'(digit);
        take     = !dot_reg || (fd_reg < 4'(dtf_pkg::MAX_FRACTION_DIGITS));
    end

    // Phase and accumulator update
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mant_next  = mant_reg;
        fd_next    = fd_reg;
        dot_next   = dot_reg;
        any_next   = any_reg;
        ovf_next   = ovf_reg;
        if (clear)
        begin
            phase_next = dtf_pkg::PH_BLANKS;
            neg_next   = 1'b0;
            mant_next  = '0;
            fd_next    = '0;
            dot_next   = 1'b0;
            any_next   = 1'b0;
            ovf_next   = 1'b0;
        end
        else if (char_valid)
        begin
            any_next = 1'b1;
            if (phase_reg != dtf_pkg::PH_ERROR)
            begin
                if (is_digit)
                begin
                    phase_next = dtf_pkg::PH_BODY;
                    if (take)
                    begin
                        if (dot_reg)
                            fd_next = fd_reg + 4'd1;
                        // saturate when the new value needs more than MW bits
                        if (prod[EW-1:MW] != 4'd0)
                        begin
                            mant_next = '1;
                            ovf_next  = 1'b1;
                        end
                        else
                        begin
                            mant_next = prod[MW-1:0];
                        end
                    end
                end
                else if (char_in == dtf_pkg::CH_DOT)
                begin
                    if (dot_reg)
                        phase_next = dtf_pkg::PH_ERROR;
                    else
                    begin
                        dot_next   = 1'b1;
                        phase_next = dtf_pkg::PH_BODY;
                    end
                end
                else if (phase_reg == dtf_pkg::PH_BLANKS && is_blank)
                begin
                    phase_next = phase_reg;
                end
                else if (phase_reg == dtf_pkg::PH_BLANKS && is_sign)
                begin
                    neg_next   = (char_in == dtf_pkg::CH_MINUS);
                    phase_next = dtf_pkg::PH_BODY;
                end
                else
                begin
                    phase_next = dtf_pkg::PH_ERROR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dtf_pkg::PH_BLANKS;
            neg_reg   <= 1'b0;
            mant_reg  <= '0;
            fd_reg    <= '0;
            dot_reg   <= 1'b0;
            any_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mant_reg  <= mant_next;
            fd_reg    <= fd_next;
            dot_reg   <= dot_next;
            any_reg   <= any_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign mantissa              = mant_reg;
    assign flags.negative        = neg_reg;
    assign flags.phase_error     = (phase_reg == dtf_pkg::PH_ERROR);
    assign flags.any_character   = any_reg;
    assign flags.overflowed      = ovf_reg;
    assign flags.fraction_digits = fd_reg;

endmodule

// ----- sv/dtf_div.sv -----
module dtf_div #(
    parameter int MANTISSA_BITS = dtf_pkg::MANTISSA_BITS_DEF,
    parameter int FRACTION_BITS = dtf_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [MANTISSA_BITS-1:0]             mantissa,
    input  logic [dtf_pkg::FD_W-1:0]             fraction_digits,
    output logic                                 done,
    output logic [MANTISSA_BITS+FRACTION_BITS-1:0] quotient
);

    localparam int NUM_W = MANTISSA_BITS + FRACTION_BITS;
    localparam int PW    = dtf_pkg::POW_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [PW:0]      rem_sh;
    logic [PW+1:0]    diff;

    // Restoring divide: one quotient bit per cycle, shifted in where the
    // numerator bits leave
    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        diff      = {1'b0, rem_sh} - {2'b0, dvs_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = NUM_W'({mantissa, {FRACTION_BITS{1'b0}}});
            rem_next  = '0;
            dvs_next  = dtf_pkg::pow10(fraction_digits);
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[PW+1])
            begin
                rem_next = diff[PW-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[PW-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

    // A new division never starts over one in flight
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // The last step is followed by the done pulse and an idle unit
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cnt_reg == CNT_W'(1)) && !start |=> done_reg && !busy_reg)
        else $error("divider did not finish after its last step");

endmodule

// ----- sv/decimal_text_to_fixed_point.sv -----
// Characters are taken one per cycle; a nonzero byte leaves no result.
// A terminator of a well-formed string starts the restoring divider, which retires one
// quotient bit per cycle, and the result is loaded once the divider reports done; an empty
// or malformed string skips the divider and goes straight to the result load.
// s_axis_tready is low from terminator acceptance until the result is loaded.
// rst_n (asynchronous, active low) clears the parser, the sequencer and the output valid.
module decimal_text_to_fixed_point #(
    parameter int MANTISSA_BITS = dtf_pkg::MANTISSA_BITS_DEF,
    parameter int FRACTION_BITS = dtf_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dtf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] character
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dtf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // [56:0] value, [58:57] status
);

    localparam int NUM_W = MANTISSA_BITS + FRACTION_BITS;
    localparam int VW    = dtf_pkg::VALUE_W;
    localparam int MAGW  = dtf_pkg::VALUE_MAG_W;
    localparam int WW    = dtf_pkg::WIDE_W;

    dtf_pkg::seq_t          state_reg, state_next;
    dtf_pkg::parse_flags_t  flags;
    logic [MANTISSA_BITS-1:0] mantissa;
    logic [NUM_W-1:0]       quotient;
    logic                   div_done;

    logic                   in_acc, term, char_valid, bad_term, div_start;
    logic                   load;
    logic                   neg_reg, neg_next;
    logic                   bad_reg, bad_next;
    logic                   ovf_reg, ovf_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VW-1:0]          value_reg, value_next;
    dtf_pkg::status_t       status_reg, status_next;

    logic [WW-1:0]          q_wide;
    logic                   q_sat;
    logic [MAGW-1:0]        mag;

    // Input transaction decode
    assign s_axis_tready = (state_reg == dtf_pkg::S_PARSE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign term          = in_acc && (s_axis_tdata == dtf_pkg::CH_NUL);
    assign char_valid    = in_acc && (s_axis_tdata != dtf_pkg::CH_NUL);
    assign bad_term      = !flags.any_character || flags.phase_error;
    assign div_start     = term && !bad_term;

    dtf_parse #(
        .MANTISSA_BITS(MANTISSA_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .clear      (term),
        .char_in    (s_axis_tdata),
        .mantissa   (mantissa),
        .flags      (flags)
    );

    dtf_div #(
        .MANTISSA_BITS(MANTISSA_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (div_start),
        .mantissa        (mantissa),
        .fraction_digits (flags.fraction_digits),
        .done            (div_done),
        .quotient        (quotient)
    );

    // Value saturation; the sign is applied when the result is loaded
    always_comb
    begin
        q_wide = WW'(quotient);
        q_sat  = q_wide > dtf_pkg::VALUE_MAX;
        mag    = q_sat ? dtf_pkg::VALUE_MAX[MAGW-1:0] : q_wide[MAGW-1:0];
    end

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        load           = 1'b0;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            dtf_pkg::S_PARSE:
            begin
                if (term)
                begin
                    neg_next   = flags.negative;
                    bad_next   = bad_term;
                    ovf_next   = flags.overflowed;
                    state_next = bad_term ? dtf_pkg::S_FIN : dtf_pkg::S_DIV;
                end
            end
            dtf_pkg::S_DIV:
            begin
                if (div_done)
                    state_next = dtf_pkg::S_FIN;
            end
            dtf_pkg::S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dtf_pkg::S_PARSE;
                    if (bad_reg)
                    begin
                        value_next  = '0;
                        status_next = dtf_pkg::ST_BAD;
                    end
                    else
                    begin
                        value_next  = neg_reg ? (VW'(0) - {1'b0, mag}) : {1'b0, mag};
                        status_next = (ovf_reg || q_sat) ? dtf_pkg::ST_SAT : dtf_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = dtf_pkg::S_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtf_pkg::S_PARSE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        bad_reg    <= bad_next;
        ovf_reg    <= ovf_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dtf_pkg::OUT_TDATA_W - VW - dtf_pkg::STATUS_W){1'b0}},
                            status_reg, value_reg};

    // A finished result waits while the output register is still occupied
    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtf_pkg::S_FIN) && out_valid_reg && !m_axis_tready
        |=> (state_reg == dtf_pkg::S_FIN))
        else $error("result dropped while output was stalled");

    // The divider only reports done while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == dtf_pkg::S_DIV))
        else $error("divider done outside the divide state");

    // An error result always carries a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load && bad_reg |=> (value_reg == '0) && (status_reg == dtf_pkg::ST_BAD))
        else $error("error result with nonzero value");

endmodule

// ----- test/tb_decimal_text_to_fixed_point.sv -----
`timescale 1ns / 1ps

// One parsed number as the block reports it
typedef struct packed {
    logic [dtf_pkg::VALUE_W-1:0] value;
    dtf_pkg::status_t            status;
} parsed_number_t;

// Tracks the parser state, predicts each number and checks what comes out
class number_checker;
    dtf_pkg::phase_t                phase;
    logic                           negative;
    logic [dtf_pkg::WIDE_W-1:0]     mantissa;
    int unsigned                    fraction_digits;
    logic                           dot_seen;
    logic                           any_character;
    logic                           overflowed;
    parsed_number_t                 expected_numbers[$];
    int                             failures;

    function new();
        failures = 0;
        clear_number();
    endfunction

    function void clear_number();
        phase           = dtf_pkg::PH_BLANKS;
        negative        = 1'b0;
        mantissa        = '0;
        fraction_digits = 0;
        dot_seen        = 1'b0;
        any_character   = 1'b0;
        overflowed      = 1'b0;
    endfunction

    // Divisor for a number of kept fraction digits
    function logic [dtf_pkg::WIDE_W-1:0] ten_power(int unsigned k);
        logic [dtf_pkg::WIDE_W-1:0] p;
        p = 64'd1;
        for (int i = 0; i < k && i < dtf_pkg::MAX_FRACTION_DIGITS; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // Saturating accumulate; excess fraction digits are dropped
    function void add_digit(logic [dtf_pkg::WIDE_W-1:0] d);
        logic [dtf_pkg::WIDE_W-1:0] mant_max;
        mant_max = (64'd1 << dtf_pkg::MANTISSA_BITS_DEF) - 64'd1;
        if (dot_seen) begin
            if (fraction_digits >= dtf_pkg::MAX_FRACTION_DIGITS)
                return;
            fraction_digits++;
        end
        if (mantissa > (mant_max - d) / 64'd10) begin
            mantissa   = mant_max;
            overflowed = 1'b1;
        end
        else begin
            mantissa = mantissa * 64'd10 + d;
        end
    endfunction

    // Called for each accepted character transaction
    function void note_char(logic [dtf_pkg::CHAR_W-1:0] ch);
        logic                       is_blank;
        logic [dtf_pkg::WIDE_W-1:0] q;
        parsed_number_t             num;
        is_blank = (ch == dtf_pkg::CH_SPACE) ||
                   (ch >= dtf_pkg::CH_TAB && ch <= dtf_pkg::CH_CR);
        if (ch != dtf_pkg::CH_NUL) begin
            any_character = 1'b1;
            if (phase == dtf_pkg::PH_ERROR)
                return;
            if (ch >= dtf_pkg::CH_ZERO && ch <= dtf_pkg::CH_NINE) begin
                phase = dtf_pkg::PH_BODY;
                add_digit(64'(ch - dtf_pkg::CH_ZERO));
            end
            else if (ch == dtf_pkg::CH_DOT) begin
                if (dot_seen)
                    phase = dtf_pkg::PH_ERROR;
                else begin
                    dot_seen = 1'b1;
                    phase    = dtf_pkg::PH_BODY;
                end
            end
            else if (phase == dtf_pkg::PH_BLANKS && is_blank) begin
                // leading blank, skipped
            end
            else if (phase == dtf_pkg::PH_BLANKS &&
                     (ch == dtf_pkg::CH_MINUS || ch == dtf_pkg::CH_PLUS)) begin
                negative = (ch == dtf_pkg::CH_MINUS);
                phase    = dtf_pkg::PH_BODY;
            end
            else begin
                phase = dtf_pkg::PH_ERROR;
            end
            return;
        end
        // Terminator: empty or malformed text wins over saturation
        if (!any_character || phase == dtf_pkg::PH_ERROR) begin
            num.value  = '0;
            num.status = dtf_pkg::ST_BAD;
        end
        else begin
            num.status = overflowed ? dtf_pkg::ST_SAT : dtf_pkg::ST_OK;
            q = (mantissa << dtf_pkg::FRACTION_BITS_DEF) / ten_power(fraction_digits);
            if (q > dtf_pkg::VALUE_MAX) begin
                q          = dtf_pkg::VALUE_MAX;
                num.status = dtf_pkg::ST_SAT;
            end
            if (negative)
                q = -q;
            num.value = q[dtf_pkg::VALUE_W-1:0];
        end
        expected_numbers.push_back(num);
        clear_number();
    endfunction

    // Called for each accepted result transaction
    function void check_result(logic [dtf_pkg::OUT_TDATA_W-1:0] tdata);
        parsed_number_t                want;
        logic [dtf_pkg::VALUE_W-1:0]   got_value;
        logic [dtf_pkg::STATUS_W-1:0]  got_status;
        got_value  = tdata[dtf_pkg::VALUE_W-1:0];
        got_status = tdata[dtf_pkg::VALUE_W+dtf_pkg::STATUS_W-1:dtf_pkg::VALUE_W];
        if (expected_numbers.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: result with none expected: value %h status %0d",
                         got_value, got_status);
            return;
        end
        want = expected_numbers.pop_front();
        if (got_value !== want.value || got_status !== want.status) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: value exp %h got %h, status exp %0d got %0d",
                         want.value, got_value, want.status, got_status);
        end
    endfunction

    function int pending();
        return expected_numbers.size();
    endfunction
endclass

module tb_decimal_text_to_fixed_point;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [dtf_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] character
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [dtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [56:0] value, [58:57] status

    number_checker checker_h = new();

    int          src_idle_pct;
    int          sink_stall_pct;
    int          quiet_cycles;
    int unsigned chars_sent;
    logic [dtf_pkg::CHAR_W-1:0] text_q[$];

    decimal_text_to_fixed_point dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result-side backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor both sides and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                checker_h.note_char(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                checker_h.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // One character transaction, with random gaps before it
    task automatic send_char(input logic [dtf_pkg::CHAR_W-1:0] ch);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    // Sends the queued text followed by the terminator
    task automatic send_text();
        while (text_q.size() != 0)
            send_char(text_q.pop_front());
        send_char(dtf_pkg::CH_NUL);
    endtask

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [dtf_pkg::CHAR_W-1:0] any_digit();
        return dtf_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [dtf_pkg::CHAR_W-1:0] any_blank();
        if ($urandom_range(5) == 0)
            return dtf_pkg::CH_SPACE;
        return dtf_pkg::CH_TAB + 8'($urandom_range(4));
    endfunction

    // Well-formed number: blanks, sign, integer digits, dot, fraction digits
    task automatic push_number();
        int n;
        n = $urandom_range(3);
        repeat (n) text_q.push_back(any_blank());
        if ($urandom_range(1))
            text_q.push_back($urandom_range(1) ? dtf_pkg::CH_MINUS : dtf_pkg::CH_PLUS);
        n = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(5);
        repeat (n) text_q.push_back(any_digit());
        if ($urandom_range(1)) begin
            text_q.push_back(dtf_pkg::CH_DOT);
            n = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(4);
            repeat (n) text_q.push_back(any_digit());
        end
    endtask

    // Random text until the phase has sent its share of characters
    task automatic random_texts(input int unsigned count);
        int unsigned stop_at;
        int kind;
        int pos;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                push_number();
            end
            else if (kind < 85) begin
                // well-formed text with one stray byte somewhere
                push_number();
                pos = $urandom_range(text_q.size());
                text_q.insert(pos, 8'($urandom_range(255, 1)));
            end
            else if (kind < 95) begin
                repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255, 1)));
            end
            send_text();
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        m_axis_tready  <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        quiet_cycles   = 0;
        chars_sent     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty, blanks with sign and a dot with no integer digits, lone sign,
        // second dot, top byte, negative zero, saturation, dropped fraction digits
        send_text();
        push_string("\t\v\r -.5");
        send_text();
        push_string("+");
        send_text();
        push_string("1.2.");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        push_string("-0");
        send_text();
        push_string("99999999999999");
        send_text();
        push_string(".12345678901234");
        send_text();

        // Random, under each idle pattern
        src_idle_pct = 0;  sink_stall_pct = 0;
        random_texts(150);
        src_idle_pct = 63; sink_stall_pct = 0;
        random_texts(150);
        src_idle_pct = 0;  sink_stall_pct = 63;
        random_texts(150);
        src_idle_pct = 35; sink_stall_pct = 35;
        random_texts(150);
        s_axis_tvalid <= 1'b0;

        // let the monitor note the last terminator before waiting on results
        @(posedge clk);
        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (checker_h.failures == 0 && checker_h.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
